[src/srht_pkg.sv]
// Shared types, constants and command structs for the striped refcount hash table.
// No dependencies; the controller, datapath and top level import this package.
package srht_pkg;

	localparam int STRIPES     = 16;
	localparam int STRIPE_BITS = 4;
	localparam int MAX_SLOTS   = 64;
	localparam int SLOT_BITS   = $clog2(MAX_SLOTS);
	localparam int ADDR_BITS   = STRIPE_BITS + SLOT_BITS;
	localparam int DEPTH       = STRIPES * MAX_SLOTS;
	localparam int KEY_BITS    = 84;
	localparam int REF_BITS    = 32;
	localparam int LIVE_BITS   = SLOT_BITS + 1;
	localparam int WORD_BITS   = 2 + KEY_BITS + REF_BITS;
	localparam int MIN_LOG     = 4;

	localparam logic [1:0] KIND_SUB    = 2'd0;
	localparam logic [1:0] KIND_UNSUB  = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_CREATED   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EVICTED   = 3'd4;

	localparam logic [2:0] SLOTS_LOG2_RESET = 3'd6;

	typedef struct packed {
		logic [1:0]         kind;
		logic [63:0]        key_hash;
		logic [31:0]        zone_id;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
		logic [3:0]         detail_level;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [REF_BITS-1:0]  ref_count;
		logic                 stripe_full;
		logic [LIVE_BITS-1:0] stripe_live;
	} out_item_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_ISSUE, S_CHECK, S_UPDATE, S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic issue;
		logic check;
		logic update;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic stop;
		logic out_free;
	} stat_t;

endpackage

[src/srht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/srht_ctrl.sv]
// Controller state machine: clearing pass, probe loop sequencing, response.
// Depends on srht_pkg.
module srht_ctrl import srht_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stat_t  stat,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (stat.clr_done) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = S_ISSUE;
			S_ISSUE:  state_d = S_CHECK;
			S_CHECK:  state_d = stat.stop ? S_UPDATE : S_ISSUE;
			S_UPDATE: state_d = S_RESP;
			S_RESP:   if (stat.out_free) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR:  cmd.clear = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_ISSUE:  cmd.issue = 1'b1;
			S_CHECK:  cmd.check = 1'b1;
			S_UPDATE: cmd.update = 1'b1;
			S_RESP:   cmd.respond = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

[src/srht_dp.sv]
// Datapath: item and probe registers, slot RAM, stripe counts, result and output registers.
// Depends on srht_pkg and srht_ram.
module srht_dp import srht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output stat_t      stat,
	input  in_item_t   in_item,
	input  logic       cfg_valid,
	input  logic [2:0] cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item
);

	in_item_t             item_q;
	logic [2:0]           slots_log2_q;
	logic [ADDR_BITS-1:0] clr_q;
	logic [SLOT_BITS-1:0] p_q;
	logic                 found_q, fresh_q, tomb_v_q;
	logic [ADDR_BITS-1:0] addr_q, tomb_q;
	logic [REF_BITS-1:0]  refs_q;
	logic [LIVE_BITS-1:0] cnt_q [STRIPES];
	out_item_t            res_q, out_q;
	logic                 out_valid_q;

	logic [2:0]             lg;
	logic [LIVE_BITS-1:0]   nslots;
	logic [SLOT_BITS-1:0]   mask, home, slot;
	logic [STRIPE_BITS-1:0] stripe;
	logic [ADDR_BITS-1:0]   cur, waddr;
	logic [KEY_BITS-1:0]    key;
	logic [WORD_BITS-1:0]   rdata, wdata, upd_word;
	logic                   r_used, r_del, keq, upd_we;
	logic [LIVE_BITS-1:0]   cnt, cnt_new;
	logic [REF_BITS-1:0]    refs_new;
	logic [2:0]             st_new;
	logic [REF_BITS-1:0]    dec;

	// slot count from the register, clamped to the legal range
	always_comb begin
		lg = slots_log2_q;
		if (lg < 3'(MIN_LOG)) lg = 3'(MIN_LOG);
		if (lg > 3'(SLOT_BITS)) lg = 3'(SLOT_BITS);
	end
	assign nslots = LIVE_BITS'(1) << lg;
	assign mask   = SLOT_BITS'(nslots - LIVE_BITS'(1));
	assign stripe = item_q.key_hash[STRIPE_BITS-1:0];
	assign home   = item_q.key_hash[STRIPE_BITS +: SLOT_BITS] & mask;
	assign slot   = (home + p_q) & mask;
	assign cur    = {stripe, slot};
	assign key    = {item_q.zone_id, item_q.coord_x, item_q.coord_y, item_q.coord_z,
		item_q.detail_level};

	// probe word fields
	assign r_used = rdata[WORD_BITS-1];
	assign r_del  = rdata[WORD_BITS-2];
	assign keq    = (rdata[REF_BITS +: KEY_BITS] == key);

	assign stat.clr_done = cmd.clear && (clr_q == ADDR_BITS'(DEPTH - 1));
	assign stat.stop     = !r_used || (!r_del && keq) || (p_q == mask);
	assign stat.out_free = !out_valid_q || out_ready;

	// work out the table update for this item
	assign cnt = cnt_q[stripe];
	assign dec = refs_q - REF_BITS'(refs_q != '0);
	always_comb begin
		upd_we   = 1'b0;
		upd_word = '0;
		cnt_new  = cnt;
		refs_new = '0;
		st_new   = ST_NOT_FOUND;
		priority if (item_q.kind == KIND_SUB) begin
			if (found_q) begin
				refs_new = (refs_q == '1) ? refs_q : refs_q + REF_BITS'(1);
				upd_we   = 1'b1;
				upd_word = {2'b10, key, refs_new};
				st_new   = ST_HIT;
			end else if (tomb_v_q || fresh_q) begin
				refs_new = REF_BITS'(1);
				upd_we   = 1'b1;
				upd_word = {2'b10, key, refs_new};
				cnt_new  = cnt + LIVE_BITS'(1);
				st_new   = ST_CREATED;
			end else begin
				st_new = ST_FULL;
			end
		end else if (item_q.kind == KIND_UNSUB) begin
			if (found_q) begin
				upd_we = 1'b1;
				if (dec != '0) begin
					refs_new = dec;
					upd_word = {2'b10, key, dec};
					st_new   = ST_HIT;
				end else begin
					upd_word = {2'b11, key, dec};
					cnt_new  = (cnt != '0) ? cnt - LIVE_BITS'(1) : cnt;
					st_new   = ST_EVICTED;
				end
			end
		end else begin
			if (found_q) begin
				refs_new = refs_q;
				st_new   = ST_HIT;
			end
		end
	end

	// write port: clearing pass or update
	always_comb begin
		if (cmd.clear) begin
			waddr = clr_q;
			wdata = '0;
		end else begin
			waddr = (found_q || !tomb_v_q) ? addr_q : tomb_q;
			wdata = upd_word;
		end
	end

	srht_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.clear || (cmd.update && upd_we)),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cur),
		.rdata (rdata)
	);

	// control registers: config, clear counter, counts, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_log2_q <= SLOTS_LOG2_RESET;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < STRIPES; i++) cnt_q[i] <= '0;
		end else begin
			if (cfg_valid) slots_log2_q <= cfg_data;
			if (cmd.clear) clr_q <= clr_q + ADDR_BITS'(1);
			if (cmd.update) cnt_q[stripe] <= cnt_new;
			if (cmd.respond && stat.out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: item, probe state, result, output
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= in_item;
			p_q      <= '0;
			found_q  <= 1'b0;
			fresh_q  <= 1'b0;
			tomb_v_q <= 1'b0;
		end
		if (cmd.check) begin
			p_q <= p_q + SLOT_BITS'(1);
			priority if (!r_used) begin
				fresh_q <= 1'b1;
				addr_q  <= cur;
			end else if (r_del) begin
				if (!tomb_v_q) begin
					tomb_v_q <= 1'b1;
					tomb_q   <= cur;
				end
			end else if (keq) begin
				found_q <= 1'b1;
				addr_q  <= cur;
				refs_q  <= rdata[REF_BITS-1:0];
			end
		end
		if (cmd.update) begin
			res_q.status      <= st_new;
			res_q.ref_count   <= refs_new;
			res_q.stripe_full <= (cnt_new >= nslots);
			res_q.stripe_live <= cnt_new;
		end
		if (cmd.respond && stat.out_free) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[src/striped_refcount_hash_table.sv]
// Top level of the striped refcount hash table: controller, datapath, checks.
// Depends on srht_pkg, srht_ctrl and srht_dp.

// Each item probes its stripe one slot at a time through a slot RAM with one write
// port, one read port and registered read: the item is registered, each probe
// issues a read and checks the registered word, between 1 and all of the slots in
// use are probed, then the update is written and the result moves to the output
// register, which waits while an earlier result still sits there. The next item is
// taken only after that. After reset the block runs a clearing pass over all 1024
// slots and takes no item until it finishes; configuration writes are taken at any
// time. A new item is taken while the previous result waits in the output.
module striped_refcount_hash_table import srht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	srht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// an accepted item starts its probe next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.issue)
		else $error("probe did not start after transfer");

	// a created entry always reports a count of one
	a_created: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status == ST_CREATED) |-> (out_item.ref_count == 32'd1))
		else $error("created entry with count other than one");

	// evicted, missing and full-stripe results report no count
	a_nocount: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.status == ST_EVICTED || out_item.status == ST_NOT_FOUND
		|| out_item.status == ST_FULL)) |-> (out_item.ref_count == 32'd0))
		else $error("absent entry with non-zero count");

	// live count never exceeds the physical slots of a stripe
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.stripe_live <= LIVE_BITS'(MAX_SLOTS)))
		else $error("stripe live count out of range");

endmodule
